// File: design/bmpt_pkg.sv
// Package for the binomial modulo prime table block.
// Holds widths, table depth, status codes and opcodes. No dependencies.
package bmpt_pkg;
    localparam int TableBound = 1023;
    localparam int IdxW = 10;
    localparam int ValW = 31;
    localparam logic [ValW-1:0] ModulusReset = 31'd1000000007;
    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StRAboveN = 2'd1;
    localparam logic [1:0] StNotBuilt = 2'd2;
    localparam logic OpBuild = 1'b0;
    localparam logic OpQuery = 1'b1;
    typedef logic [ValW-1:0] val_t;
    typedef logic [IdxW-1:0] idx_t;
endpackage

// File: design/bmpt_if.sv
// Channel interfaces for the binomial modulo prime table block.
// Depends on bmpt_pkg.
interface bmpt_in_if import bmpt_pkg::*; ();
    logic valid;
    logic ready;
    logic opcode;
    idx_t top_count;
    idx_t choose_count;
    modport source (output valid, opcode, top_count, choose_count, input ready);
    modport sink (input valid, opcode, top_count, choose_count, output ready);
endinterface

interface bmpt_out_if import bmpt_pkg::*; ();
    logic valid;
    logic ready;
    val_t coefficient;
    logic [1:0] status;
    modport source (output valid, coefficient, status, input ready);
    modport sink (input valid, coefficient, status, output ready);
endinterface

interface bmpt_cfg_if import bmpt_pkg::*; ();
    logic valid;
    logic ready;
    val_t data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// File: design/bmpt_mulmod.sv
// Shift-add modular multiplier, one bit of the multiplier per cycle.
// Depends on bmpt_pkg.
module bmpt_mulmod
    import bmpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  val_t a,
    input  val_t b,
    input  val_t m,
    output logic done,
    output val_t prod
);
    localparam int CntW = $clog2(ValW + 1);
    logic busy_reg, busy_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    val_t acc_reg, acc_next;
    val_t a_reg, a_next;
    val_t b_reg, b_next;
    logic [ValW:0] dbl;
    logic [ValW:0] dsub;
    val_t dred;
    logic [ValW:0] sum;
    logic [ValW:0] ssub;

    always_comb
    begin
        dbl = {acc_reg, 1'b0};
        dsub = dbl - {1'b0, m};
        dred = dsub[ValW] ? dbl[ValW-1:0] : dsub[ValW-1:0];
        if (dbl >= {1'b0, m})
            dred = dsub[ValW-1:0];
        else
            dred = dbl[ValW-1:0];
        sum = {1'b0, dred} + (b_reg[ValW-1] ? {1'b0, a_reg} : '0);
        ssub = sum - {1'b0, m};
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        a_next = a_reg;
        b_next = b_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = CntW'(ValW);
            acc_next = '0;
            a_next = (a >= m) ? a - m : a;
            b_next = b;
        end
        else if (busy_reg)
        begin
            acc_next = (sum >= {1'b0, m}) ? ssub[ValW-1:0] : sum[ValW-1:0];
            b_next = {b_reg[ValW-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
                busy_next = 1'b0;
        end
    end

    assign done = busy_reg && (cnt_reg == CntW'(1));
    assign prod = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg <= a_next;
        b_reg <= b_next;
    end
endmodule

// File: design/bmpt_divmod.sv
// Restoring divider of the modulus by a table index, one quotient bit a cycle.
// Depends on bmpt_pkg.
module bmpt_divmod
    import bmpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  val_t num,
    input  idx_t den,
    output logic done,
    output val_t quo,
    output idx_t rem
);
    localparam int CntW = $clog2(ValW + 1);
    logic busy_reg;
    logic [CntW-1:0] cnt_reg;
    val_t q_reg;
    logic [IdxW:0] r_reg;
    idx_t d_reg;
    logic [IdxW:0] sh;
    logic [IdxW:0] diff;
    logic ge;

    always_comb
    begin
        sh = {r_reg[IdxW-1:0], q_reg[ValW-1]};
        diff = sh - {1'b0, d_reg};
        ge = sh >= {1'b0, d_reg};
    end

    assign done = busy_reg && (cnt_reg == CntW'(1));
    assign quo = {q_reg[ValW-2:0], ge};
    assign rem = ge ? diff[IdxW-1:0] : sh[IdxW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= CntW'(ValW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[ValW-2:0], ge};
            r_reg <= ge ? diff : sh;
        end
    end
endmodule

// File: design/binomial_mod_prime_table.sv
// Binomial coefficient modulo a prime, served from factorial tables.
// Depends on bmpt_pkg, bmpt_if, bmpt_mulmod and bmpt_divmod.
//
// Channels: in (opcode, top_count, choose_count), out (coefficient, status),
// cfg (modulus write). Every transfer uses valid and ready.
// A build item (opcode 0) fills the inverse, inverse factorial and factorial
// tables for the current modulus and returns coefficient 0, status 0.
// A query item (opcode 1) returns n choose r mod p or an error status.
// One item is in work at a time; in.ready is low until its result is taken.
// All modular products go through one shift-add multiplier.
// A query passes two table read states and two products before out.valid;
// an error status shows in the cycle after its transfer.
// A build fills the inverse, then the inverse factorial, then the factorial
// table; each inverse entry first divides p by the index, then multiplies.
// Reset clears the ready flag of the tables; contents are left as they are.
// A modulus write also marks the tables not built.
// When out.ready is low the result holds and no new item is taken.
module binomial_mod_prime_table
    import bmpt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    bmpt_cfg_if.sink cfg,
    bmpt_in_if.sink in,
    bmpt_out_if.source out
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INV_DIV = 4'd1;
    localparam logic [3:0] S_INV_RD = 4'd2;
    localparam logic [3:0] S_INV_MUL = 4'd3;
    localparam logic [3:0] S_IF_RD = 4'd4;
    localparam logic [3:0] S_IF_MUL = 4'd5;
    localparam logic [3:0] S_F_MUL = 4'd6;
    localparam logic [3:0] S_Q_RD1 = 4'd7;
    localparam logic [3:0] S_Q_RD2 = 4'd8;
    localparam logic [3:0] S_Q_MUL1 = 4'd9;
    localparam logic [3:0] S_Q_MUL2 = 4'd10;
    localparam logic [3:0] S_OUT = 4'd11;
    localparam logic [3:0] S_Q_WAIT = 4'd12;

    val_t fact_mem [TableBound+1];
    val_t inv_mem [TableBound+1];
    val_t ifact_mem [TableBound+1];

    logic [3:0] state_reg;
    val_t modulus_reg;
    logic ready_tbl_reg;
    idx_t i_reg;
    idx_t n_reg, r_reg;
    val_t res_reg;
    logic [1:0] status_reg;
    val_t rd_inv, rd_fact, rd_ifact;
    val_t opa_reg, opb_reg;
    val_t tmp_reg;
    idx_t back_reg;
    val_t quo_reg;

    logic mm_start, mm_done;
    val_t mm_prod;
    logic dv_start, dv_done;
    val_t dv_quo;
    idx_t dv_rem;
    logic small_m;

    idx_t inv_addr, fact_addr, ifact_addr;
    logic inv_we, fact_we, ifact_we;
    val_t wdata;

    assign small_m = modulus_reg < 31'd2;
    assign cfg.ready = (state_reg == S_IDLE);
    assign in.ready = (state_reg == S_IDLE) && !cfg.valid;
    assign out.valid = (state_reg == S_OUT);
    assign out.coefficient = res_reg;
    assign out.status = status_reg;

    bmpt_mulmod u_mul (
        .clk(clk), .rst_n(rst_n), .start(mm_start), .a(opa_reg), .b(opb_reg),
        .m(modulus_reg), .done(mm_done), .prod(mm_prod)
    );

    bmpt_divmod u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .num(modulus_reg), .den(i_reg),
        .done(dv_done), .quo(dv_quo), .rem(dv_rem)
    );

    logic mm_go_reg;
    logic dv_busy_reg;
    assign mm_start = mm_go_reg;
    assign dv_start = (state_reg == S_INV_DIV) && !mm_go_reg && !dv_busy_reg;

    always_comb
    begin
        inv_addr = i_reg;
        fact_addr = i_reg;
        ifact_addr = i_reg;
        inv_we = 1'b0;
        fact_we = 1'b0;
        ifact_we = 1'b0;
        wdata = small_m ? '0 : mm_prod;
        case (state_reg)
            S_INV_RD:
                inv_addr = back_reg;
            S_INV_MUL:
                inv_we = mm_done;
            S_IF_RD:
                ifact_addr = i_reg - 1'b1;
            S_IF_MUL:
                ifact_we = mm_done;
            S_F_MUL:
                fact_we = mm_done;
            S_Q_RD1:
            begin
                fact_addr = n_reg;
                ifact_addr = r_reg;
            end
            S_Q_RD2, S_Q_MUL1:
                ifact_addr = n_reg - r_reg;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (inv_we)
            inv_mem[inv_addr] <= wdata;
        rd_inv <= inv_mem[inv_addr];
    end

    always_ff @(posedge clk)
    begin
        if (fact_we)
            fact_mem[fact_addr] <= wdata;
        rd_fact <= fact_mem[fact_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ifact_we)
            ifact_mem[ifact_addr] <= wdata;
        rd_ifact <= ifact_mem[ifact_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            modulus_reg <= ModulusReset;
            ready_tbl_reg <= 1'b0;
            mm_go_reg <= 1'b0;
            dv_busy_reg <= 1'b0;
            i_reg <= '0;
        end
        else
        begin
            mm_go_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg.valid)
                    begin
                        modulus_reg <= cfg.data;
                        ready_tbl_reg <= 1'b0;
                    end
                    else if (in.valid)
                    begin
                        n_reg <= in.top_count;
                        r_reg <= in.choose_count;
                        res_reg <= '0;
                        status_reg <= StOk;
                        if (in.opcode == OpBuild)
                        begin
                            i_reg <= IdxW'(2);
                            state_reg <= S_INV_DIV;
                        end
                        else if (!ready_tbl_reg)
                        begin
                            status_reg <= StNotBuilt;
                            state_reg <= S_OUT;
                        end
                        else if (in.choose_count > in.top_count)
                        begin
                            status_reg <= StRAboveN;
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_Q_RD1;
                    end
                end
                S_INV_DIV:
                begin
                    if (dv_start)
                        dv_busy_reg <= 1'b1;
                    if (dv_done)
                    begin
                        dv_busy_reg <= 1'b0;
                        back_reg <= dv_rem;
                        quo_reg <= dv_quo;
                        state_reg <= S_INV_RD;
                    end
                end
                S_INV_RD:
                begin
                    state_reg <= S_Q_WAIT;
                    tmp_reg <= modulus_reg - quo_reg;
                end
                S_Q_WAIT:
                begin
                    opa_reg <= (back_reg < IdxW'(2)) ? 31'd1 : rd_inv;
                    opb_reg <= tmp_reg;
                    mm_go_reg <= 1'b1;
                    state_reg <= S_INV_MUL;
                end
                S_INV_MUL:
                begin
                    if (mm_done)
                    begin
                        if (i_reg == IdxW'(TableBound))
                        begin
                            i_reg <= IdxW'(2);
                            state_reg <= S_IF_RD;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                            state_reg <= S_INV_DIV;
                        end
                    end
                end
                S_IF_RD:
                begin
                    if (!mm_go_reg && !dv_busy_reg)
                    begin
                        dv_busy_reg <= 1'b1;
                    end
                    else if (dv_busy_reg)
                    begin
                        dv_busy_reg <= 1'b0;
                        opa_reg <= (i_reg == IdxW'(2)) ? 31'd1 : rd_ifact;
                        mm_go_reg <= 1'b1;
                        state_reg <= S_IF_MUL;
                    end
                    opb_reg <= rd_inv;
                end
                S_IF_MUL:
                begin
                    if (mm_done)
                    begin
                        if (i_reg == IdxW'(TableBound))
                        begin
                            i_reg <= IdxW'(1);
                            opa_reg <= small_m ? '0 : 31'd1;
                            opb_reg <= 31'd1;
                            mm_go_reg <= 1'b1;
                            state_reg <= S_F_MUL;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                            state_reg <= S_IF_RD;
                        end
                    end
                end
                S_F_MUL:
                begin
                    if (mm_done)
                    begin
                        opa_reg <= wdata;
                        opb_reg <= ValW'(i_reg + 1'b1);
                        if (i_reg == IdxW'(TableBound))
                        begin
                            ready_tbl_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                            mm_go_reg <= 1'b1;
                        end
                    end
                end
                S_Q_RD1:
                    state_reg <= S_Q_RD2;
                S_Q_RD2:
                begin
                    opa_reg <= (n_reg == '0) ? 31'd1 : rd_fact;
                    opb_reg <= (r_reg < IdxW'(2)) ? 31'd1 : rd_ifact;
                    mm_go_reg <= 1'b1;
                    state_reg <= S_Q_MUL1;
                end
                S_Q_MUL1:
                begin
                    if (mm_done)
                    begin
                        opa_reg <= mm_prod;
                        opb_reg <= ((n_reg - r_reg) < IdxW'(2)) ? 31'd1 : rd_ifact;
                        mm_go_reg <= 1'b1;
                        state_reg <= S_Q_MUL2;
                    end
                end
                S_Q_MUL2:
                begin
                    if (mm_done)
                    begin
                        res_reg <= small_m ? '0 : mm_prod;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out.ready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
